// File: rtl/krs_pkg.sv
// key auto-repeat selector: shared types, reset values and the key-to-code table
// no dependencies
package krs_pkg;

  localparam int unsigned NUM_KEYS = 10;

  localparam logic [31:0] INITIAL_DELAY_RESET   = 32'(21428 / 2);
  localparam logic [31:0] REPEAT_INTERVAL_RESET = 32'(21428 / 10);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INITIAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } hold_mode_t;

  typedef enum logic {
    REG_INITIAL_DELAY   = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    CODE_NONE   = 4'd0,
    CODE_UP     = 4'd1,
    CODE_DOWN   = 4'd2,
    CODE_LEFT   = 4'd3,
    CODE_RIGHT  = 4'd4,
    CODE_LTRIG  = 4'd5,
    CODE_RTRIG  = 4'd6,
    CODE_SELECT = 4'd7,
    CODE_BACK   = 4'd8,
    CODE_EXIT   = 4'd9,
    CODE_TOUCH  = 4'd10
  } cursor_code_t;

  // rank order: A, B, X, L, R, touch, up, down, left, right
  function automatic cursor_code_t rank_to_code(input logic [3:0] rank);
    cursor_code_t code;
    unique case (rank)
      4'd0:    code = CODE_SELECT;
      4'd1:    code = CODE_BACK;
      4'd2:    code = CODE_EXIT;
      4'd3:    code = CODE_LTRIG;
      4'd4:    code = CODE_RTRIG;
      4'd5:    code = CODE_TOUCH;
      4'd6:    code = CODE_UP;
      4'd7:    code = CODE_DOWN;
      4'd8:    code = CODE_LEFT;
      4'd9:    code = CODE_RIGHT;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/key_auto_repeat_selector_unit.sv
// key auto-repeat selector, top level: input register, hold/repeat logic, result register
// depends on krs_pkg
//
//  channel  | dir | handshake         | content
//  ---------+-----+-------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | one poll: keys, touch position, time stamp
//  m_*      | out | m_tvalid/m_tready | one result per poll: cursor code and position
//  cfg_*    | in  | cfg_we            | initial delay (0), repeat interval (1)
//
// one poll per cycle sustained while the output is not stalled; a poll's result passes through
// the input register and then the result register
// (between them, one pass of priority encode and 32-bit subtract-compare)
// hold state updates as each poll moves into the result register, so the next poll sees it
// rst clears hold state and both valid flags and resets the configuration registers; no clearing pass
// a stalled output holds its result; the input register stalls behind it
module key_auto_repeat_selector_unit
  import krs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pressed_keys[9:0], touch_x[17:10], touch_y[25:18], now_time[57:26]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cursor_code[3:0], report_x[11:4], report_y[19:12]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic        in_valid;
  logic [9:0]  in_keys;
  logic [7:0]  in_x;
  logic [7:0]  in_y;
  logic [31:0] in_now_time;

  logic [31:0] initial_delay;
  logic [31:0] repeat_interval;

  hold_mode_t  hold_mode;
  hold_mode_t  hold_mode_next;
  logic [31:0] hold_start_time;
  logic [31:0] hold_start_time_next;
  logic [3:0]  held_key_index;
  logic [3:0]  held_key_index_next;

  logic         out_valid;
  cursor_code_t cursor_code;
  cursor_code_t cursor_code_next;
  logic [7:0]   report_x;
  logic [7:0]   report_x_next;
  logic [7:0]   report_y;
  logic [7:0]   report_y_next;

  logic        advance;
  logic [3:0]  first_rank;
  logic        any_pressed;
  logic        still_held;
  logic [31:0] elapsed;
  logic [31:0] limit;
  logic [9:0]  shifted_keys;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, report_y, report_x, cursor_code};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay   <= INITIAL_DELAY_RESET;
      repeat_interval <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_INITIAL_DELAY:   initial_delay   <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_keys     <= s_tdata[9:0];
      in_x        <= s_tdata[17:10];
      in_y        <= s_tdata[25:18];
      in_now_time <= s_tdata[57:26];
    end
  end

  // priority encode, lowest bit wins
  always_comb begin
    first_rank = 4'(NUM_KEYS);
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (in_keys[i]) first_rank = 4'(i);
    end
  end

  assign any_pressed  = |in_keys;
  assign shifted_keys = in_keys >> held_key_index;
  assign still_held   = (held_key_index < 4'(NUM_KEYS)) && shifted_keys[0];
  assign elapsed      = in_now_time - hold_start_time;
  assign limit        = (hold_mode == MODE_INITIAL) ? initial_delay : repeat_interval;

  always_comb begin
    hold_mode_next       = hold_mode;
    hold_start_time_next = hold_start_time;
    held_key_index_next  = held_key_index;
    cursor_code_next     = CODE_NONE;
    report_x_next        = 8'd0;
    report_y_next        = 8'd0;
    if ((hold_mode == MODE_INITIAL || hold_mode == MODE_REPEAT) && still_held) begin
      if (elapsed >= limit) begin
        hold_mode_next       = (first_rank == held_key_index) ? MODE_REPEAT : MODE_INITIAL;
        hold_start_time_next = in_now_time;
        held_key_index_next  = first_rank;
        cursor_code_next     = rank_to_code(first_rank);
        report_x_next        = in_x;
        report_y_next        = in_y;
      end
    end else if (any_pressed) begin
      // idle, released or unknown mode: fresh evaluation
      hold_mode_next       = MODE_INITIAL;
      hold_start_time_next = in_now_time;
      held_key_index_next  = first_rank;
      cursor_code_next     = rank_to_code(first_rank);
      report_x_next        = in_x;
      report_y_next        = in_y;
    end else begin
      hold_mode_next = MODE_IDLE;
    end
  end

  // hold state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_mode       <= MODE_IDLE;
      hold_start_time <= 32'd0;
      held_key_index  <= 4'd0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        hold_mode       <= hold_mode_next;
        hold_start_time <= hold_start_time_next;
        held_key_index  <= held_key_index_next;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cursor_code <= cursor_code_next;
      report_x    <= report_x_next;
      report_y    <= report_y_next;
    end
  end

  a_held_index_range: assert property (@(posedge clk) disable iff (rst)
    (hold_mode != MODE_IDLE) |-> (held_key_index < 4'(NUM_KEYS)))
    else $error("held key index out of range while holding");

  a_report_retimes: assert property (@(posedge clk) disable iff (rst)
    (advance && cursor_code_next != CODE_NONE) |=> (hold_start_time == $past(in_now_time)))
    else $error("report did not restart the hold timer");

  a_idle_means_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hold_mode == MODE_IDLE) |-> (cursor_code == CODE_NONE))
    else $error("idle state after a reported key");

  a_silent_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cursor_code == CODE_NONE) |-> (report_x == 8'd0 && report_y == 8'd0))
    else $error("position reported without a key");

endmodule
